@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the bitonic sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bitonic sorter assertion failed");
`define BS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("bitonic sorter forbidden condition seen");
`else
`define BS_ASSERT(lbl, clk, rstn, prop)
`define BS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ hw/rtl/bsort_pkg.sv @@
// Types shared by the bitonic sorter modules.
package bsort_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_LOAD     = 8'b0000_0001,
    S_SIZE     = 8'b0000_0010,
    S_PAD      = 8'b0000_0100,
    S_RD       = 8'b0000_1000,
    S_CMP      = 8'b0001_0000,
    S_WR2      = 8'b0010_0000,
    S_EMIT_RD  = 8'b0100_0000,
    S_EMIT_OUT = 8'b1000_0000
  } state_t;

  // Strobes from the sequencer to the element memory.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

@@ hw/rtl/bsort_mem.sv @@
// Element memory: one write port, two registered read ports.
module bsort_mem #(
  parameter int DATA_WIDTH = 32,
  parameter int ADDR_WIDTH = 6
) (
  input  logic                  clk,
  input  bsort_pkg::mem_ctl_t   ctl,
  input  logic [ADDR_WIDTH-1:0] waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [ADDR_WIDTH-1:0] raddr_a,
  input  logic [ADDR_WIDTH-1:0] raddr_b,
  output logic [DATA_WIDTH-1:0] rdata_a,
  output logic [DATA_WIDTH-1:0] rdata_b
);
  import bsort_pkg::*;

  localparam int Depth = 1 << ADDR_WIDTH;

  logic [DATA_WIDTH-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/bsort_cmpx.sv @@
// Shared compare unit: decides whether a compare-exchange pair must swap.
module bsort_cmpx #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] lo_val,
  input  logic [DATA_WIDTH-1:0] hi_val,
  input  logic                  up,
  output logic                  swap
);
  import bsort_pkg::*;

  logic lo_greater;

  // Signed order: the lower slot holds the larger value.
  assign lo_greater = $signed(lo_val) > $signed(hi_val);
  // Ascending runs swap when the lower slot is larger, descending runs otherwise.
  assign swap = (lo_greater == up);

endmodule

@@ hw/rtl/bitonic_sorter_core.sv @@
// After the last value the core sizes the set, pads it, then runs L(L+1)/2 network stages of
// P/2 pairs, each pair read, compared and written back (a second write on a swap), and emits.
// P is N rounded up to a power of two, L = log2(P).
// One set is handled at a time: the input reopens only after the last value is emitted.
// The speed is set by the single compare unit and the one write port of the element memory.
// Reset (rst_n low, synchronous) empties the set; the memory contents are not cleared.
module bitonic_sorter_core #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  in_last_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_sorted_value,
  output logic                  out_last_out
);
  import bsort_pkg::*;
  `include "assert_macros.svh"

  // AW addresses the memory, IW holds sizes up to the full padded depth,
  // CW holds the count of values up to MAX_ITEMS.
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int IW = AW + 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_ITEMS);
  localparam logic [DATA_WIDTH-1:0] MostNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] max_r, max_nxt;
  logic [IW-1:0] size_r, size_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [CW-1:0] e_r, e_nxt;

  mem_ctl_t mem_ctl;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic [IW-1:0] cnt_ext, partner;
  logic [IW:0] inc1, inc2;
  logic up, swap, in_acc, out_acc, emit_last;

  // The element memory holds the set and the padding; the network works in place.
  bsort_mem #(
    .DATA_WIDTH(DATA_WIDTH),
    .ADDR_WIDTH(AW)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // One compare unit serves every compare-exchange of the network.
  bsort_cmpx #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cmpx (
    .lo_val(rdata_a),
    .hi_val(rdata_b),
    .up    (up),
    .swap  (swap)
  );

  assign in_ready         = (state_r == S_LOAD);
  assign out_valid        = (state_r == S_EMIT_OUT);
  assign in_acc           = in_valid && in_ready;
  assign out_acc          = out_valid && out_ready;
  assign out_sorted_value = rdata_a;
  assign emit_last        = (e_r == cnt_r - CW'(1));
  assign out_last_out     = emit_last;

  assign cnt_ext = IW'(cnt_r);
  // The partner of slot i sits j above it; i always has the j bit clear.
  assign partner = i_r ^ j_r;
  // A run sorts ascending when the k bit of the slot index is clear.
  assign up      = ((i_r & k_r) == '0);

  // Next slot with the j bit clear: step by one, and skip the upper half of a block.
  assign inc1 = {1'b0, i_r} + (IW+1)'(1);
  always_comb begin
    if ((inc1[IW-1:0] & j_r) != '0) begin
      inc2 = inc1 + {1'b0, j_r};
    end else begin
      inc2 = inc1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    max_nxt     = max_r;
    size_nxt    = size_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    i_nxt       = i_r;
    e_nxt       = e_r;
    mem_ctl.we  = 1'b0;
    mem_ctl.re  = 1'b0;
    waddr       = i_r[AW-1:0];
    wdata       = max_r;
    raddr_a     = i_r[AW-1:0];
    raddr_b     = partner[AW-1:0];

    unique case (state_r)
      S_LOAD: begin
        waddr = cnt_r[AW-1:0];
        wdata = in_value;
        if (in_acc) begin
          // Values beyond MAX_ITEMS are dropped, but a final one still starts the sort.
          if (cnt_r < CntMax) begin
            mem_ctl.we = 1'b1;
            cnt_nxt    = cnt_r + CW'(1);
            if (cnt_r == '0 || $signed(in_value) > $signed(max_r)) begin
              max_nxt = in_value;
            end
          end
          if (in_last_in) begin
            size_nxt  = IW'(1);
            state_nxt = S_SIZE;
          end
        end
      end

      S_SIZE: begin
        // Round the count up to a power of two, one doubling a cycle.
        if (size_r < cnt_ext) begin
          size_nxt = size_r << 1;
        end else begin
          i_nxt     = cnt_ext;
          state_nxt = S_PAD;
        end
      end

      S_PAD: begin
        // Fill the slots above the set with its largest value.
        if (i_r < size_r) begin
          mem_ctl.we = 1'b1;
          waddr      = i_r[AW-1:0];
          wdata      = max_r;
          i_nxt      = i_r + IW'(1);
        end else if (size_r == IW'(1)) begin
          e_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          k_nxt     = IW'(2);
          j_nxt     = IW'(1);
          i_nxt     = '0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        mem_ctl.re = 1'b1;
        state_nxt  = S_CMP;
      end

      S_CMP, S_WR2: begin
        // On a swap the lower slot is written in S_CMP and the upper one in S_WR2.
        if (state_r == S_CMP) begin
          waddr = i_r[AW-1:0];
          wdata = rdata_b;
        end else begin
          waddr = partner[AW-1:0];
          wdata = rdata_a;
        end
        mem_ctl.we = (state_r == S_WR2) || swap;
        if (state_r == S_CMP && swap) begin
          state_nxt = S_WR2;
        end else if (inc2 < {1'b0, size_r}) begin
          i_nxt     = inc2[IW-1:0];
          state_nxt = S_RD;
        end else begin
          // End of a network stage: halve the distance, or open the next merge size.
          i_nxt = '0;
          if (j_r != IW'(1)) begin
            j_nxt     = j_r >> 1;
            state_nxt = S_RD;
          end else if (k_r != size_r) begin
            k_nxt     = k_r << 1;
            j_nxt     = k_r;
            state_nxt = S_RD;
          end else begin
            e_nxt     = '0;
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_EMIT_RD: begin
        mem_ctl.re = 1'b1;
        raddr_a    = e_r[AW-1:0];
        state_nxt  = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        // The read data register holds the request until it is taken.
        if (out_acc) begin
          if (emit_last) begin
            cnt_nxt   = '0;
            max_nxt   = MostNeg;
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + CW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      max_r   <= MostNeg;
      size_r  <= IW'(1);
      k_r     <= IW'(2);
      j_r     <= IW'(1);
      i_r     <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      max_r   <= max_nxt;
      size_r  <= size_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      e_r     <= e_nxt;
    end
  end

  // Loading and emitting never overlap.
  `BS_NEVER(a_load_emit_excl, clk, rst_n, in_ready && out_valid)
  // The set never holds more than MAX_ITEMS values.
  `BS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CntMax)
  // The second write of an exchange only follows a compare that swapped.
  `BS_ASSERT(a_wr2_after_cmp, clk, rst_n, (state_r == S_WR2) |-> ($past(state_r) == S_CMP))
  // Taking the final request empties the set and reopens the input.
  `BS_ASSERT(a_last_reopens, clk, rst_n, (out_acc && out_last_out) |=> (in_ready && cnt_r == '0))

endmodule
